[design/hrl_pkg.sv]
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared constants, codes and the hex-digit decode helper of the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package hrl_pkg;

   localparam int CharWidth    = 8;
   localparam int KindWidth    = 3;
   localparam int AddrWidth    = 17;
   localparam int ByteWidth    = 8;
   localparam int NibbleWidth  = 4;
   localparam int RecAddrWidth = 16;

   localparam logic [CharWidth-1:0] REC_START = 8'h3A;

   localparam logic [KindWidth-1:0] EV_DATA   = 3'd0;
   localparam logic [KindWidth-1:0] EV_GOOD   = 3'd1;
   localparam logic [KindWidth-1:0] EV_EOF    = 3'd2;
   localparam logic [KindWidth-1:0] EV_CKSUM  = 3'd3;
   localparam logic [KindWidth-1:0] EV_FORMAT = 3'd4;

   localparam logic [ByteWidth-1:0] TYPE_DATA = 8'h00;
   localparam logic [ByteWidth-1:0] TYPE_EOF  = 8'h01;

   typedef struct packed {
      logic                   valid;
      logic [NibbleWidth-1:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [CharWidth-1:0] c);
      hex_digit_type r;
      r.valid = 1'b1;
      r.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = NibbleWidth'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = NibbleWidth'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = NibbleWidth'(c - 8'h57);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/hrl_req_if.sv]
// ----------------------------------------------------------------------------
// hrl_req_if
// Character channel into the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrl_req_if
   import hrl_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

[design/hrl_rsp_if.sv]
// ----------------------------------------------------------------------------
// hrl_rsp_if
// Event channel out of the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrl_rsp_if
   import hrl_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] event_kind;
   logic [AddrWidth-1:0] byte_address;
   logic [ByteWidth-1:0] byte_value;
   logic [AddrWidth-1:0] image_length;

   modport source (output valid, output event_kind, output byte_address,
                   output byte_value, output image_length, input ready);
   modport sink   (input valid, input event_kind, input byte_address,
                   input byte_value, input image_length, output ready);
endinterface

`default_nettype wire

[design/hex_record_loader_top.sv]
// ----------------------------------------------------------------------------
// hex_record_loader_top
// Streaming hex-record parser: one ASCII character in, at most one event out.
//
// The req_if channel carries one character per word. The rsp_if channel
// carries events: a tentative data byte with its image address, record good,
// end of file, checksum error or format error, each with the image length.
// A character is decoded in the cycle it is accepted and its event, if any,
// appears on rsp_if in the next cycle.
// The block takes one character per cycle unless an event is stalled; the single
// output register is refilled in the same cycle in which its word is taken.
// When the receiver stalls with an event pending, req_if.ready drops and no
// further character is taken until the event leaves.
// After an end-of-file record or a checksum or format error the block takes
// every character and produces nothing until reset.
// Synchronous reset returns the parser to hunting for a record start and
// clears the image length and the output valid flag, but not the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_loader_top
   import hrl_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   hrl_req_if.sink     req_if,
   hrl_rsp_if.source   rsp_if
);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_ADDR   = 3'd2;
   localparam logic [2:0] PH_TYPE   = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_CKSUM  = 3'd5;
   localparam logic [2:0] PH_ENDED  = 3'd6;
   localparam logic [2:0] PH_HALTED = 3'd7;

   logic [2:0]              phase_ff, phase_in;
   logic [2:0]              nibble_ff, nibble_in;
   logic [NibbleWidth-1:0]  high_ff, high_in;
   logic [ByteWidth-1:0]    length_ff, length_in;
   logic [RecAddrWidth-1:0] rec_addr_ff, rec_addr_in;
   logic [ByteWidth-1:0]    sum_ff, sum_in;
   logic [ByteWidth-1:0]    offset_ff, offset_in;
   logic [AddrWidth-1:0]    highest_ff, highest_in;

   logic                    rsp_valid_ff;
   logic [KindWidth-1:0]    kind_ff, kind_in;
   logic [AddrWidth-1:0]    addr_ff, addr_in;
   logic [ByteWidth-1:0]    value_ff, value_in;
   logic [AddrWidth-1:0]    length_out_ff;

   logic                    accept;
   logic                    emit;
   hex_digit_type           digit;
   logic [ByteWidth-1:0]    byte_val;
   logic [ByteWidth-1:0]    sum_next;
   logic [ByteWidth-1:0]    offset_next;
   logic [AddrWidth-1:0]    end_addr;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign digit       = hex_decode(req_if.char_in);
   assign byte_val    = {high_ff, digit.value};
   assign sum_next    = sum_ff + byte_val;
   assign offset_next = offset_ff + 8'd1;
   assign end_addr    = {1'b0, rec_addr_ff} + {{(AddrWidth-ByteWidth){1'b0}}, length_ff};

   always_comb begin
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      high_in     = high_ff;
      length_in   = length_ff;
      rec_addr_in = rec_addr_ff;
      sum_in      = sum_ff;
      offset_in   = offset_ff;
      highest_in  = highest_ff;
      emit        = 1'b0;
      kind_in     = EV_DATA;
      addr_in     = '0;
      value_in    = '0;
      if (accept) begin
         unique case (phase_ff) inside
            PH_HUNT: begin
               if (req_if.char_in == REC_START) begin
                  phase_in  = PH_LEN;
                  nibble_in = '0;
                  sum_in    = '0;
               end
            end
            PH_ENDED, PH_HALTED: begin
            end
            default: begin
               if (!digit.valid) begin
                  phase_in = PH_HALTED;
                  emit     = 1'b1;
                  kind_in  = EV_FORMAT;
               end else if (!nibble_ff[0]) begin
                  high_in   = digit.value;
                  nibble_in = nibble_ff + 3'd1;
               end else begin
                  nibble_in = nibble_ff + 3'd1;
                  unique case (phase_ff)
                     PH_LEN: begin
                        length_in = byte_val;
                        sum_in    = byte_val;
                        phase_in  = PH_ADDR;
                        nibble_in = '0;
                     end
                     PH_ADDR: begin
                        rec_addr_in = {rec_addr_ff[ByteWidth-1:0], byte_val};
                        sum_in      = sum_next;
                        if (nibble_ff == 3'd3) begin
                           phase_in  = PH_TYPE;
                           nibble_in = '0;
                        end
                     end
                     PH_TYPE: begin
                        sum_in    = sum_next;
                        nibble_in = '0;
                        offset_in = '0;
                        if (byte_val == TYPE_DATA) begin
                           phase_in = (length_ff != '0) ? PH_DATA : PH_CKSUM;
                        end else if (byte_val == TYPE_EOF) begin
                           phase_in = PH_ENDED;
                           emit     = 1'b1;
                           kind_in  = EV_EOF;
                        end else begin
                           phase_in = PH_HUNT;
                        end
                     end
                     PH_DATA: begin
                        sum_in    = sum_next;
                        offset_in = offset_next;
                        nibble_in = '0;
                        if (offset_next >= length_ff) begin
                           phase_in = PH_CKSUM;
                        end
                        emit     = 1'b1;
                        kind_in  = EV_DATA;
                        addr_in  = {1'b0, rec_addr_ff}
                                 + {{(AddrWidth-ByteWidth){1'b0}}, offset_ff};
                        value_in = byte_val;
                     end
                     PH_CKSUM: begin
                        nibble_in = '0;
                        emit      = 1'b1;
                        if (sum_next == '0) begin
                           if (end_addr > highest_ff) begin
                              highest_in = end_addr;
                           end
                           phase_in = PH_HUNT;
                           kind_in  = EV_GOOD;
                        end else begin
                           phase_in = PH_HALTED;
                           kind_in  = EV_CKSUM;
                        end
                     end
                     default: begin
                        phase_in = PH_HALTED;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         nibble_ff    <= '0;
         high_ff      <= '0;
         length_ff    <= '0;
         rec_addr_ff  <= '0;
         sum_ff       <= '0;
         offset_ff    <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         nibble_ff   <= nibble_in;
         high_ff     <= high_in;
         length_ff   <= length_in;
         rec_addr_ff <= rec_addr_in;
         sum_ff      <= sum_in;
         offset_ff   <= offset_in;
         highest_ff  <= highest_in;
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff       <= kind_in;
         addr_ff       <= addr_in;
         value_ff      <= value_in;
         length_out_ff <= highest_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.event_kind   = kind_ff;
   assign rsp_if.byte_address = addr_ff;
   assign rsp_if.byte_value   = value_ff;
   assign rsp_if.image_length = length_out_ff;

   // The end-of-file state holds until reset.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ENDED |=> phase_ff == PH_ENDED)
      else $error("parser left the end-of-file state");

   // The image length only grows between resets.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> highest_ff >= $past(highest_ff))
      else $error("image length decreased");

   // Address bytes are counted in at most four digits.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ADDR |-> nibble_ff < 3'd4)
      else $error("address digit count overran");

   // Only data events carry an address and a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != EV_DATA |-> addr_ff == '0 && value_ff == '0)
      else $error("non-data event carries payload");

endmodule

`default_nettype wire
